// File: rtl/sld_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sld_pkg
// Types and constants shared by the sync/length deframer files.
// ----------------------------------------------------------------------------
package sld_pkg;

  localparam int unsigned HdrBytes    = 3;
  localparam int unsigned PosWidth    = 9;
  localparam int unsigned TickWidth   = 16;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDatWidth = 16;

  localparam logic [PosWidth-1:0]  CountMax   = '1;
  localparam logic [TickWidth-1:0] ElapsedMax = '1;

  localparam logic [7:0]           SyncFirstReset   = 8'd170;
  localparam logic [7:0]           SyncSecondReset  = 8'd85;
  localparam logic [TickWidth-1:0] TimeoutTickReset = 16'd100;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgSyncFirst  = 2'd0,
    CfgSyncSecond = 2'd1,
    CfgTimeout    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PhHunt    = 2'd0,
    PhSecond  = 2'd1,
    PhLength  = 2'd2,
    PhPayload = 2'd3
  } phase_e;

  typedef enum logic {
    ModeByte = 1'b0,
    ModeTick = 1'b1
  } mode_e;

  typedef enum logic {
    StatByte  = 1'b0,
    StatAbort = 1'b1
  } status_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          frame_byte;
    logic [PosWidth-1:0] position;
    logic                last;
    logic                status;
  } out_item_t;

  typedef struct packed {
    logic [7:0]           sync_first;
    logic [7:0]           sync_second;
    logic [TickWidth-1:0] timeout_ticks;
  } cfg_t;

endpackage
`default_nettype wire

// File: rtl/sync_length_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sync_length_deframer
// Receive deframer for frames of two sync bytes, a length byte and payload.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   in       sink       in_valid_i/in_stall_o  sld_pkg::in_item_t (mode, rx_byte)
//   out      source     out_valid_o/out_stall_i sld_pkg::out_item_t
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// The frame state is updated in the cycle an item is transferred and any
// result lands in the output register. An item can be taken every cycle
// while the input is not stalled; the state update is one compare and
// count step. Reset clears the frame state, empties the output register and
// loads the default register values. The input stalls only while a result
// waits in the output register and the sink stalls it.
//
module sync_length_deframer (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire sld_pkg::in_item_t                  in_item_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output sld_pkg::out_item_t                      out_item_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [sld_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  wire logic [sld_pkg::CfgDatWidth-1:0]    cfg_data_i
);

  sld_pkg::cfg_t      cfg_q;
  logic               in_xfer;
  logic               res_valid;
  sld_pkg::out_item_t res;
  logic               out_valid_q, out_valid_d;
  sld_pkg::out_item_t out_q;

  // Configuration writes are always accepted; the block is idle by contract.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first    <= sld_pkg::SyncFirstReset;
      cfg_q.sync_second   <= sld_pkg::SyncSecondReset;
      cfg_q.timeout_ticks <= sld_pkg::TimeoutTickReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        sld_pkg::CfgSyncFirst:  cfg_q.sync_first    <= cfg_data_i[7:0];
        sld_pkg::CfgSyncSecond: cfg_q.sync_second   <= cfg_data_i[7:0];
        sld_pkg::CfgTimeout:    cfg_q.timeout_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A new item is taken whenever the output register is free or drains.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  sld_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_xfer),
    .item_i      (in_item_i),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // The output register holds while stalled, otherwise refills or empties.
  always_comb begin
    if (in_xfer && res_valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

// File: rtl/sld_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sld_core
// Frame state and the combinational step that turns an item into a result.
// ----------------------------------------------------------------------------
module sld_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire sld_pkg::in_item_t item_i,
  input  wire sld_pkg::cfg_t     cfg_i,
  output logic                   res_valid_o,
  output sld_pkg::out_item_t     res_o
);

  sld_pkg::phase_e                  phase_q, phase_d;
  logic [sld_pkg::PosWidth-1:0]     count_q, count_d;
  logic [7:0]                       length_q, length_d;
  logic [sld_pkg::TickWidth-1:0]    elapsed_q, elapsed_d;
  logic                             active_q, active_d;

  logic [sld_pkg::TickWidth-1:0]    elapsed_inc;
  logic [sld_pkg::PosWidth-1:0]     count_inc;
  logic                             final_byte;

  assign elapsed_inc = (elapsed_q != sld_pkg::ElapsedMax) ?
                       elapsed_q + 1'b1 : elapsed_q;
  assign count_inc   = (count_q != sld_pkg::CountMax) ? count_q + 1'b1 : count_q;
  // Compare position + 1 against length + header in a widened domain.
  assign final_byte  = (length_q != 8'd0) &&
                       ({1'b0, count_q} + 10'd1 >=
                        {2'b00, length_q} + 10'(sld_pkg::HdrBytes));

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    length_d    = length_q;
    elapsed_d   = elapsed_q;
    active_d    = active_q;
    res_valid_o = 1'b0;
    res_o       = '{frame_byte: item_i.rx_byte, position: count_q,
                    last: 1'b0, status: sld_pkg::StatByte};
    if (item_i.mode == sld_pkg::ModeTick) begin
      res_o.frame_byte = 8'd0;
      res_o.position   = '0;
      if (active_q) begin
        elapsed_d = elapsed_inc;
        if (elapsed_inc >= cfg_i.timeout_ticks) begin
          phase_d     = sld_pkg::PhHunt;
          count_d     = '0;
          length_d    = 8'd0;
          elapsed_d   = '0;
          active_d    = 1'b0;
          res_valid_o = 1'b1;
          res_o.status = sld_pkg::StatAbort;
        end
      end
    end else begin
      if (!active_q) begin
        active_d  = 1'b1;
        elapsed_d = '0;
      end
      unique case (phase_q)
        sld_pkg::PhHunt: begin
          if (item_i.rx_byte == cfg_i.sync_first) begin
            phase_d     = sld_pkg::PhSecond;
            count_d     = count_inc;
            res_valid_o = 1'b1;
          end
        end
        sld_pkg::PhSecond: begin
          if (item_i.rx_byte == cfg_i.sync_second) begin
            phase_d     = sld_pkg::PhLength;
            count_d     = count_inc;
            res_valid_o = 1'b1;
          end
        end
        sld_pkg::PhLength: begin
          length_d    = item_i.rx_byte;
          phase_d     = sld_pkg::PhPayload;
          count_d     = count_inc;
          res_valid_o = 1'b1;
        end
        sld_pkg::PhPayload: begin
          res_valid_o = 1'b1;
          if (final_byte) begin
            phase_d    = sld_pkg::PhHunt;
            count_d    = '0;
            length_d   = 8'd0;
            elapsed_d  = '0;
            active_d   = 1'b0;
            res_o.last = 1'b1;
          end else begin
            count_d = count_inc;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= sld_pkg::PhHunt;
      count_q   <= '0;
      length_q  <= 8'd0;
      elapsed_q <= '0;
      active_q  <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      count_q   <= count_d;
      length_q  <= length_d;
      elapsed_q <= elapsed_d;
      active_q  <= active_d;
    end
  end

endmodule
`default_nettype wire

// File: dv/sld_frame_checker.sv
// ----------------------------------------------------------------------------
// sld_frame_checker
// Watches the deframer channels, predicts every result and compares.
// ----------------------------------------------------------------------------
module sld_frame_checker
  import sld_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  in_item_t               in_item_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  out_item_t              out_item_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [CfgDatWidth-1:0] cfg_data_i,
  input  logic                   drain_check_i,
  output int unsigned            pending_o,
  output int unsigned            errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t                 regs;
  phase_e               ph;
  logic [PosWidth-1:0]  nbytes;
  logic [7:0]           flen;
  logic [TickWidth-1:0] ticks;
  logic                 busy;
  bit                   drained;
  out_item_t            frame_results_q[$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors_o++;
  endtask

  function automatic void back_to_hunt();
    ph     = PhHunt;
    nbytes = '0;
    flen   = '0;
    ticks  = '0;
    busy   = 1'b0;
  endfunction

  // Advances the frame state by one item; returns 1 when the item yields a result.
  function automatic bit deframe(input in_item_t item, output out_item_t res);
    logic [PosWidth-1:0] pos;
    res = '0;
    if (item.mode == ModeTick) begin
      if (!busy) return 1'b0;
      if (ticks != ElapsedMax) ticks++;
      if (ticks >= regs.timeout_ticks) begin
        back_to_hunt();
        res.status = StatAbort;
        return 1'b1;
      end
      return 1'b0;
    end
    // Any byte starts the attempt timer, sync byte or not.
    if (!busy) begin
      busy  = 1'b1;
      ticks = '0;
    end
    pos = nbytes;
    case (ph)
      PhHunt: begin
        if (item.rx_byte != regs.sync_first) return 1'b0;
        ph = PhSecond;
      end
      PhSecond: begin
        if (item.rx_byte != regs.sync_second) return 1'b0;
        ph = PhLength;
      end
      PhLength: begin
        flen = item.rx_byte;
        ph   = PhPayload;
      end
      default: begin
        // A zero length never completes; only the timeout ends such a frame.
        if (flen != 0 && 32'(pos) + 1 >= 32'(flen) + HdrBytes) begin
          back_to_hunt();
          res.frame_byte = item.rx_byte;
          res.position   = pos;
          res.last       = 1'b1;
          return 1'b1;
        end
      end
    endcase
    if (nbytes != CountMax) nbytes++;
    res.frame_byte = item.rx_byte;
    res.position   = pos;
    return 1'b1;
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (frame_results_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result byte %02h pos %0d last %0b status %0b",
                                got.frame_byte, got.position, got.last, got.status));
      return;
    end
    want = frame_results_q.pop_front();
    if (got.frame_byte !== want.frame_byte)
      report_mismatch($sformatf("frame_byte got %02h want %02h", got.frame_byte,
                                want.frame_byte));
    if (got.position !== want.position)
      report_mismatch($sformatf("position got %0d want %0d", got.position, want.position));
    if (got.last !== want.last)
      report_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
    if (got.status !== want.status)
      report_mismatch($sformatf("status got %0b want %0b", got.status, want.status));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t res;
    if (!rst_ni) begin
      regs = '{SyncFirstReset, SyncSecondReset, TimeoutTickReset};
      back_to_hunt();
      frame_results_q.delete();
      drained   = 1'b0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_item_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgSyncFirst:  regs.sync_first    = cfg_data_i[7:0];
          CfgSyncSecond: regs.sync_second   = cfg_data_i[7:0];
          CfgTimeout:    regs.timeout_ticks = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (deframe(in_item_i, res)) frame_results_q.push_back(res);
      end
      if (drain_check_i && !drained) begin
        drained = 1'b1;
        if (frame_results_q.size() != 0)
          report_mismatch($sformatf("%0d expected results never arrived",
                                    frame_results_q.size()));
      end
      pending_o = frame_results_q.size();
    end
  end

endmodule

// File: dv/sync_length_deframer_tb.sv
// ----------------------------------------------------------------------------
// sync_length_deframer_tb
// Drives bytes and ticks into the deframer under random idling and stalls.
// A directed opening walks through sync hunting, dropped bytes, zero length
// and timeout aborts; random phases then send mostly well-formed frames with
// noise, broken frames and long frames under several register settings. The
// checker beside the block predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module sync_length_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sld_pkg::*;

  localparam int unsigned HalfPeriod = 5;
  // The receiver holds off this long once, so the output register fills and
  // the block has to stall its input while items keep coming.
  localparam int unsigned HoldCycles = 60;
  // Long enough for the zero-length frame to run into position saturation.
  localparam int unsigned LongPayload = 515;
  // Only ticks advance the timer, so a short timeout still lets the long
  // frame run to the end before the ticks abort it.
  localparam int unsigned LongTimeout = 8;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_valid    = 1'b0;
  in_item_t               in_item     = '0;
  logic                   in_stall;
  logic                   out_valid;
  logic                   out_stall   = 1'b0;
  out_item_t              out_item;
  logic                   cfg_valid   = 1'b0;
  logic                   cfg_ready;
  logic [CfgIdxWidth-1:0] cfg_index   = '0;
  logic [CfgDatWidth-1:0] cfg_data    = '0;
  logic                   drain_check = 1'b0;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned items_sent = 0;

  // Idling controls shared between the stimulus and the sink process.
  bit snd_idle = 1'b1;
  bit rcv_idle = 1'b1;
  bit hold_req = 1'b0;

  // Shadow of the register settings, used to shape the stimulus only.
  logic [7:0]  cur_sync1   = SyncFirstReset;
  logic [7:0]  cur_sync2   = SyncSecondReset;
  int unsigned cur_timeout = TimeoutTickReset;

  always #HalfPeriod clk = ~clk;

  sync_length_deframer DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  sld_frame_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_item_i     (in_item),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_item_i    (out_item),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .drain_check_i (drain_check),
    .pending_o     (outstanding),
    .errors_o      (mismatches)
  );

  // All drive tasks are entered at a falling edge and return at one. Valid is
  // left high on return, so back-to-back transfers never lower and raise it
  // within the same time step; callers drop it when a burst is over.
  task automatic push_item(input in_item_t item);
    if (snd_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    // The transfer happens on the first rising edge without a stall.
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    push_item(in_item_t'{ModeByte, b});
  endtask

  task automatic send_ticks(input int unsigned n);
    // The byte field is ignored on ticks, so it carries random bits.
    repeat (n) push_item(in_item_t'{ModeTick, 8'($urandom)});
  endtask

  // Enough ticks to abort any attempt under the current timeout.
  task automatic abort_attempt();
    send_ticks((cur_timeout == 0) ? 1 : cur_timeout);
  endtask

  // Waits until every predicted result has left the block.
  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_one(input cfg_idx_e idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic write_regs(input logic [7:0] s1, input logic [7:0] s2,
                            input logic [15:0] tmo);
    settle();
    write_one(CfgSyncFirst, 16'(s1));
    write_one(CfgSyncSecond, 16'(s2));
    write_one(CfgTimeout, tmo);
    cfg_valid   <= 1'b0;
    cur_sync1   = s1;
    cur_sync2   = s2;
    cur_timeout = tmo;
  endtask

  // Sends the headers and the first keep payload bytes of a frame. With
  // noisy set, junk may come before the first sync byte, between the sync
  // bytes, and ticks may fall between payload bytes.
  task automatic send_frame(input int unsigned len, input int unsigned keep,
                            input bit noisy);
    if (noisy && $urandom_range(0, 2) == 0) send_byte(8'($urandom));
    send_byte(cur_sync1);
    if (noisy && $urandom_range(0, 3) == 0) send_byte(8'($urandom));
    send_byte(cur_sync2);
    send_byte(8'(len));
    for (int unsigned i = 0; i < keep; i++) begin
      if (noisy && $urandom_range(0, 7) == 0) send_ticks($urandom_range(1, 3));
      send_byte(8'($urandom));
    end
  endtask

  // Random mix of traffic. Most of it is well-formed frames; the rest is
  // truncated frames, zero-length frames and loose bytes and ticks. With a
  // large timeout only clean frames are sent, since a stray zero length
  // would otherwise hold the block in the payload phase for good.
  task automatic run_random(input int unsigned n, input bit calm);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    bit          noisy;
    stop_at = items_sent + n;
    noisy   = (cur_timeout <= 64);
    while (items_sent < stop_at) begin
      if (!calm && $urandom_range(0, 11) == 0) begin
        snd_idle = $urandom_range(0, 1);
        rcv_idle = $urandom_range(0, 1);
      end
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 60) : $urandom_range(1, 10);
      if (pick < 55 || !noisy) begin
        send_frame(len, len, noisy);
      end else if (pick < 70) begin
        send_frame(len, $urandom_range(0, len - 1), noisy);
        abort_attempt();
      end else if (pick < 85) begin
        send_frame(0, $urandom_range(0, 6), noisy);
        abort_attempt();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1) == 0) send_ticks(1);
          else send_byte(8'($urandom));
        end
      end
    end
    // Leave the block hunting so the next setting starts from a clean state.
    if (noisy) abort_attempt();
  endtask

  // Sink side: random stall bursts, plus the one long hold-off on request.
  // Each falling edge carries at most one update of the stall.
  initial begin : sink_side
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end else if (rcv_idle && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Default registers: a tick while idle does nothing, a stray byte starts
    // the timer, a wrong second sync byte is dropped without restarting.
    send_ticks(1);
    send_byte(8'h00);
    send_byte(8'hAA);
    send_byte(8'h13);
    send_byte(8'h55);
    send_byte(8'h02);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_ticks(1);

    // Zero timeout: the first tick of an attempt aborts it, even while still
    // hunting. Also a zero-length frame that only the timeout can end.
    write_regs(8'h00, 8'hFF, 16'd0);
    send_byte(8'hFF);
    send_ticks(1);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h01);
    send_ticks(1);

    // Shortest complete frame, then an abort after a single tick.
    write_regs(8'hFF, 8'h00, 16'd1);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h5A);
    send_byte(8'hFF);
    send_ticks(1);

    write_regs(8'($urandom), 8'($urandom), 16'($urandom_range(5, 30)));
    run_random(120, 1'b0);

    // Equal sync bytes and the largest timeout; clean frames only.
    begin
      logic [7:0] same_sync;
      same_sync = 8'($urandom);
      write_regs(same_sync, same_sync, 16'hFFFF);
    end
    snd_idle = 1'b1;
    rcv_idle = 1'b1;
    run_random(80, 1'b0);

    // A zero-length frame long enough for the position to saturate, under a
    // long receiver hold-off while the sender keeps offering bytes. Then the
    // longest frame the length byte allows.
    write_regs(8'($urandom), 8'($urandom), 16'(LongTimeout));
    snd_idle = 1'b0;
    rcv_idle = 1'b0;
    hold_req = 1'b1;
    send_frame(0, LongPayload, 1'b0);
    send_ticks(LongTimeout);
    snd_idle = 1'b1;
    rcv_idle = 1'b1;
    send_frame(255, 255, 1'b0);

    write_regs(8'($urandom), 8'($urandom), 16'($urandom_range(2, 12)));
    snd_idle = 1'b1;
    rcv_idle = 1'b1;
    run_random(130, 1'b0);

    // Final stretch with no idling on either side.
    write_regs(8'($urandom), 8'($urandom), 16'($urandom_range(10, 40)));
    snd_idle = 1'b0;
    rcv_idle = 1'b0;
    run_random(120, 1'b1);

    in_valid <= 1'b0;
    for (int unsigned guard = 0; guard < 5000 && outstanding != 0; guard++)
      @(negedge clk);
    repeat (10) @(negedge clk);
    drain_check <= 1'b1;
    repeat (2) @(negedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Far beyond the slowest correct run, with every gap and stall at its longest.
  initial begin : watchdog
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
